FILE: hw/rtl/alm_pkg.sv
package alm_pkg;

  // Default number of data slots. Slot 0 is the sentinel and holds no data.
  localparam int unsigned CapacityDef = 256;

  // Fixed field widths of the request and response words.
  localparam int unsigned PosW = 9;
  localparam int unsigned ValW = 32;
  localparam int unsigned CntW = 9;

  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_DELETE = 1'b1
  } req_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BAD_POS  = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_FULL     = 3'd3,
    ST_BAD_SLOT = 3'd4
  } status_e;

  typedef struct packed {
    req_e             req_type;
    logic [PosW-1:0]  position;
    logic [ValW-1:0]  item_value;
  } req_t;

  typedef struct packed {
    status_e          status;
    logic [PosW-1:0]  slot_used;
    logic [CntW-1:0]  list_size;
    logic             is_linear;
  } rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_FETCH,
    S_LINK1,
    S_LINK2,
    S_DONE
  } state_e;

  // Commands from the controller to the datapath, one per step of a request.
  typedef struct packed {
    logic load_req;
    logic check;
    logic fetch;
    logic link1;
    logic link2;
    logic load_out;
  } cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic err;
    logic out_free;
  } sts_t;

endpackage

FILE: hw/rtl/array_linked_list_manager_core.sv
// Doubly linked list kept in two link memories, with a chain of free slots.
// Requests arrive on the req channel (valid/ready): an insert of a data word at
// a logical position, or the delete of a physical slot. Every request returns
// exactly one word on the rsp channel (valid/ready) with a status code, the slot
// that was written or freed, the list size and the linear-layout flag.
// A request is accepted only while the block is idle. A request that passes its
// checks goes through a check step, a link read step, two link write steps and
// the result load, and then the idle step that accepts the next word. A rejected
// request goes from the check step straight to the result load. The sequence is
// set by the single read and single write port of each link memory. The response
// word is valid once the result load has taken place; a stalled receiver delays it.
// The response sits in an output register; the block returns to idle and takes
// the next request while an earlier response still waits. It holds in its final
// step only when the output register is full and the receiver is stalling.
// Reset empties the list at once: the sentinel links are registers, the slot
// use bits are flip-flops, and a fill mark stands in for the free chain of slots
// never used, so no clearing pass is needed. The data word of an insert does
// not appear in any response and is not retained.
module array_linked_list_manager_core import alm_pkg::*; #(
  parameter int unsigned CAPACITY = CapacityDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  output logic req_ready_o,
  input  req_t req_i,
  output logic rsp_valid_o,
  input  logic rsp_ready_i,
  output rsp_t rsp_o
);

  cmd_t cmd;
  sts_t sts;

  // The controller sequences the steps of each request.
  alm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_i),
    .req_ready_o (req_ready_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // The datapath holds the list state, link memories and the output register.
  alm_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .rsp_valid_o (rsp_valid_o),
    .rsp_ready_i (rsp_ready_i),
    .rsp_o       (rsp_o)
  );

endmodule

FILE: hw/rtl/alm_ctrl.sv
module alm_ctrl import alm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  output logic req_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        // A request that fails its checks changes nothing and goes straight to the answer.
        state_d = sts_i.err ? S_DONE : S_FETCH;
      end
      S_FETCH: state_d = S_LINK1;
      S_LINK1: state_d = S_LINK2;
      S_LINK2: state_d = S_DONE;
      S_DONE: begin
        if (sts_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    req_ready_o = 1'b0;
    cmd_o       = '0;
    case (state_q)
      S_IDLE: begin
        req_ready_o    = 1'b1;
        cmd_o.load_req = req_valid_i;
      end
      S_CHECK: cmd_o.check = 1'b1;
      S_FETCH: cmd_o.fetch = 1'b1;
      S_LINK1: cmd_o.link1 = 1'b1;
      S_LINK2: cmd_o.link2 = 1'b1;
      S_DONE:  cmd_o.load_out = sts_i.out_free;
      default: cmd_o = '0;
    endcase
  end

endmodule

FILE: hw/rtl/alm_dp.sv
module alm_dp import alm_pkg::*; #(
  parameter int unsigned CAPACITY = CapacityDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  req_t req_i,
  input  cmd_t cmd_i,
  output sts_t sts_o,
  output logic rsp_valid_o,
  input  logic rsp_ready_i,
  output rsp_t rsp_o
);

  localparam int unsigned SlotW = $clog2(CAPACITY + 1);
  localparam int unsigned AW    = ((SlotW > PosW) ? SlotW : PosW) + 2;
  localparam logic [AW-1:0]    CapA = AW'(CAPACITY);
  localparam logic [SlotW-1:0] CapS = SlotW'(CAPACITY);

  // Request fields held for the duration of one request.
  req_e            kind_q;
  logic [PosW-1:0] pos_q;

  // List state. The sentinel's links live in head_q and tail_q.
  logic [SlotW-1:0] head_q, tail_q, free_q, live_q;
  logic [SlotW:0]   fresh_q;
  logic             lin_q;
  logic [CAPACITY:0] used_q;

  // Working registers of the current request.
  logic [SlotW-1:0] anchor_q, slot_q, link_a_q, link_b_q, nf_q;
  status_e          status_q;

  rsp_t rsp_q;
  logic rsp_valid_q;

  // Link memories with registered read data.
  logic [SlotW-1:0] next_mem [CAPACITY+1];
  logic [SlotW-1:0] prev_mem [CAPACITY+1];
  logic [SlotW-1:0] nrd_q, prd_q;
  logic [SlotW-1:0] nra, pra, nwa, pwa, nwd, pwd;
  logic             nwe, pwe;

  // Check logic.
  logic [AW-1:0]    pos_w, live_w, head_w, tail_w, anchor_w;
  logic [SlotW-1:0] anchor_s, slot_s;
  logic             anchor_in, anchor_live, slot_in, slot_live, lin_keep, virgin;
  status_e          chk_status;

  assign pos_w  = AW'(pos_q);
  assign live_w = AW'(live_q);
  assign head_w = AW'(head_q);
  assign tail_w = AW'(tail_q);

  always_comb begin
    if (pos_w == AW'(1)) begin
      anchor_w = '0;
    end else if (pos_w > live_w) begin
      anchor_w = tail_w;
    end else begin
      anchor_w = head_w + pos_w - AW'(2);
    end
  end

  assign anchor_s    = anchor_w[SlotW-1:0];
  assign anchor_in   = (anchor_w <= CapA);
  assign anchor_live = anchor_in ? used_q[anchor_s] : 1'b0;
  assign slot_s      = pos_w[SlotW-1:0];
  assign slot_in     = (pos_w != '0) && (pos_w <= CapA);
  assign slot_live   = slot_in ? used_q[slot_s] : 1'b0;

  always_comb begin
    chk_status = ST_OK;
    lin_keep   = 1'b1;
    if (kind_q == REQ_INSERT) begin
      if (pos_w == '0) begin
        chk_status = ST_BAD_POS;
      end else if (free_q == '0) begin
        chk_status = ST_FULL;
      end else if (!anchor_in) begin
        chk_status = ST_BAD_POS;
      end else if ((anchor_w != '0) && !anchor_live) begin
        chk_status = ST_BAD_POS;
      end
      lin_keep = (anchor_s == tail_q);
    end else begin
      if (live_q == '0) begin
        chk_status = ST_EMPTY;
      end else if (!slot_live) begin
        chk_status = ST_BAD_SLOT;
      end
      lin_keep = (slot_s == tail_q) || (slot_s == head_q);
    end
  end

  assign sts_o.err      = (chk_status != ST_OK);
  assign sts_o.out_free = !rsp_valid_q || rsp_ready_i;

  // A slot at or above the fill mark has never been written; its free-chain
  // link is still the one it had after reset.
  assign virgin = ({1'b0, slot_q} == fresh_q);

  // Memory port selection.
  always_comb begin
    nra = free_q;
    pra = slot_s;
    if (cmd_i.check) begin
      nra = (kind_q == REQ_INSERT) ? anchor_s : slot_s;
    end
    nwe = 1'b0;
    nwa = slot_q;
    nwd = link_a_q;
    pwe = 1'b0;
    pwa = slot_q;
    pwd = anchor_q;
    if (cmd_i.link1) begin
      if (kind_q == REQ_INSERT) begin
        nwe = 1'b1;
        pwe = 1'b1;
      end else begin
        nwe = (link_b_q != '0);
        nwa = link_b_q;
        nwd = link_a_q;
        pwe = (link_a_q != '0);
        pwa = link_a_q;
        pwd = link_b_q;
      end
    end else if (cmd_i.link2) begin
      if (kind_q == REQ_INSERT) begin
        nwe = (anchor_q != '0);
        nwa = anchor_q;
        nwd = slot_q;
        pwe = (link_a_q != '0);
        pwa = link_a_q;
        pwd = slot_q;
      end else begin
        nwe = 1'b1;
        nwd = free_q;
        pwe = 1'b1;
        pwd = '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (nwe) begin
      next_mem[nwa] <= nwd;
    end
    nrd_q <= next_mem[nra];
  end

  always_ff @(posedge clk_i) begin
    if (pwe) begin
      prev_mem[pwa] <= pwd;
    end
    prd_q <= prev_mem[pra];
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      kind_q <= req_i.req_type;
      pos_q  <= req_i.position;
    end
    if (cmd_i.check) begin
      status_q <= chk_status;
      anchor_q <= anchor_s;
      slot_q   <= (kind_q == REQ_INSERT) ? free_q : slot_s;
    end
    if (cmd_i.fetch) begin
      if (kind_q == REQ_INSERT) begin
        link_a_q <= (anchor_q == '0) ? head_q : nrd_q;
      end else begin
        link_a_q <= nrd_q;
        link_b_q <= prd_q;
      end
    end
    if (cmd_i.link1) begin
      if (virgin) begin
        nf_q <= (slot_q == CapS) ? '0 : slot_q + SlotW'(1);
      end else begin
        nf_q <= nrd_q;
      end
    end
  end

  // List state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      free_q  <= SlotW'(1);
      live_q  <= '0;
      fresh_q <= (SlotW+1)'(1);
      lin_q   <= 1'b1;
      used_q  <= '0;
    end else begin
      if (cmd_i.check && (chk_status == ST_OK) && !lin_keep) begin
        lin_q <= 1'b0;
      end
      if (cmd_i.link1) begin
        if (kind_q == REQ_INSERT) begin
          if (virgin) begin
            fresh_q <= fresh_q + (SlotW+1)'(1);
          end
        end else begin
          if (link_b_q == '0) begin
            head_q <= link_a_q;
          end
          if (link_a_q == '0) begin
            tail_q <= link_b_q;
          end
        end
      end
      if (cmd_i.link2) begin
        if (kind_q == REQ_INSERT) begin
          if (anchor_q == '0) begin
            head_q <= slot_q;
          end
          if (link_a_q == '0) begin
            tail_q <= slot_q;
          end
          free_q         <= nf_q;
          live_q         <= live_q + SlotW'(1);
          used_q[slot_q] <= 1'b1;
        end else begin
          free_q         <= slot_q;
          live_q         <= live_q - SlotW'(1);
          used_q[slot_q] <= 1'b0;
        end
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      rsp_q.status    <= status_q;
      rsp_q.slot_used <= (status_q == ST_OK) ? PosW'(slot_q) : '0;
      rsp_q.list_size <= CntW'(live_q);
      rsp_q.is_linear <= lin_q;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

FILE: hw/rtl/alm_checker.sv
module alm_checker import alm_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic req_valid_i,
  input logic req_ready_o,
  input logic rsp_valid_o,
  input logic rsp_ready_i,
  input rsp_t rsp_o
);

  // A stalled response stays put.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && !rsp_ready_i |=> rsp_valid_o && $stable(rsp_o))
    else $error("response changed while stalled");

  // Only one request is worked on at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_o |=> !req_ready_o)
    else $error("request accepted while another is in progress");

  // A new response is loaded only while the block is busy with its request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_o) |-> !$past(req_ready_o))
    else $error("response appeared without a request in progress");

  // A successful request names a real slot.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && (rsp_o.status == ST_OK) |-> (rsp_o.slot_used != '0))
    else $error("successful response without a slot");

  // A failed request names no slot.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && (rsp_o.status != ST_OK) |-> (rsp_o.slot_used == '0))
    else $error("failed response with a slot");

endmodule

bind array_linked_list_manager_core alm_checker u_alm_checker (.*);
